// ===== design/hrmof_pkg.sv =====
// Package: beat types, status and register codes, reset values for the heart-rate filter.
package hrmof_pkg;

    typedef enum logic [2:0] {
        ST_ACCEPTED = 3'd0,
        ST_INVALID  = 3'd1,
        ST_RANGE    = 3'd2,
        ST_OUTLIER  = 3'd3,
        ST_RESET    = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        CFG_RATE_MIN     = 2'd0,
        CFG_RATE_MAX     = 2'd1,
        CFG_DEVIATION    = 2'd2,
        CFG_REJECT_LIMIT = 2'd3
    } t_cfg_idx;

    localparam logic [7:0] RATE_MIN_RST     = 8'd40;
    localparam logic [7:0] RATE_MAX_RST     = 8'd180;
    localparam logic [6:0] DEVIATION_RST    = 7'd20;
    localparam logic [3:0] REJECT_LIMIT_RST = 4'd3;
    localparam logic [7:0] PERCENT_SCALE    = 8'd100;

    // sort key: msb set marks an empty cell, which orders above any reading
    typedef logic [8:0] t_key;
    localparam t_key KEY_EMPTY = 9'h100;

    typedef struct packed {
        logic signed [10:0] rate;
        logic               rate_valid;
    } t_in;

    typedef struct packed {
        logic signed [8:0] filtered_rate;
        t_status           status;
    } t_out;

    typedef struct packed {
        logic       upd;
        logic       rem;
        logic       clr;
        logic [7:0] x;
        logic [7:0] y;
    } t_sort_ctl;

endpackage

// ===== design/heart_rate_median_outlier_filter.sv =====
// Top level: heart-rate running median filter with range and outlier rejection.
//
//  channel  dir  handshake                  payload
//  in       in   i_in_valid / o_in_ready    i_in  (rate, rate_valid)
//  out      out  o_out_valid / i_out_ready  o_out (filtered_rate, status)
//  cfg      in   i_cfg_we                   i_cfg_idx, i_cfg_data
//
// One beat in per cycle while the output buffer has room; its result sits in the output buffer the next cycle.
// The limit is the combinational path through the sorted cell row update and median select.
// Synchronous active-low reset loads register defaults and empties the history.
// Input is taken while the two-entry output buffer has a free slot.
module heart_rate_median_outlier_filter #(
    parameter int HISTORY_DEPTH      = 5,
    parameter int MIN_FILL_FOR_CHECK = 3
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  hrmof_pkg::t_in   i_in,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output hrmof_pkg::t_out  o_out,
    input  logic             i_cfg_we,
    input  logic [1:0]       i_cfg_idx,
    input  logic [7:0]       i_cfg_data
);

    localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);
    localparam int IDX_W = $clog2(HISTORY_DEPTH);

    logic [7:0]       r_rate_min;
    logic [7:0]       r_rate_max;
    logic [6:0]       r_dev;
    logic [3:0]       r_limit;

    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic [3:0]       r_run;
    logic [3:0]       n_run;
    logic [7:0]       r_hist [HISTORY_DEPTH];
    logic [7:0]       n_hist [HISTORY_DEPTH];

    hrmof_pkg::t_sort_ctl w_ctl;
    hrmof_pkg::t_key      w_key     [HISTORY_DEPTH];
    hrmof_pkg::t_key      w_rem_key [HISTORY_DEPTH];
    logic                 w_le      [HISTORY_DEPTH];
    logic [7:0]           w_val     [HISTORY_DEPTH];
    logic [7:0]           w_nxt     [HISTORY_DEPTH];

    hrmof_pkg::t_status   w_status;
    hrmof_pkg::t_out      w_res;
    logic                 w_acc;
    logic                 w_buf_ready;
    logic                 w_in_range;
    logic                 w_outlier;
    logic                 w_take;
    logic                 w_full;
    logic [7:0]           w_y;
    logic [7:0]           w_med;
    logic [7:0]           w_diff;
    logic [14:0]          w_dev100;
    logic [14:0]          w_lim;
    logic [3:0]           w_run_inc;
    logic [IDX_W-1:0]     w_med_idx;
    logic [IDX_W-1:0]     w_new_idx;
    logic [IDX_W-1:0]     w_wpos;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate_min <= hrmof_pkg::RATE_MIN_RST;
            r_rate_max <= hrmof_pkg::RATE_MAX_RST;
            r_dev      <= hrmof_pkg::DEVIATION_RST;
            r_limit    <= hrmof_pkg::REJECT_LIMIT_RST;
        end else if (i_cfg_we) begin
            case (hrmof_pkg::t_cfg_idx'(i_cfg_idx))
                hrmof_pkg::CFG_RATE_MIN:     r_rate_min <= i_cfg_data;
                hrmof_pkg::CFG_RATE_MAX:     r_rate_max <= i_cfg_data;
                hrmof_pkg::CFG_DEVIATION:    r_dev      <= i_cfg_data[6:0];
                hrmof_pkg::CFG_REJECT_LIMIT: r_limit    <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    assign o_in_ready = w_buf_ready;
    assign w_acc      = i_in_valid && w_buf_ready;

    // prior median from the sorted row
    assign w_med_idx = IDX_W'(r_count >> 1);
    assign w_med     = w_val[w_med_idx];
    assign w_y       = i_in.rate[7:0];

    assign w_in_range = (i_in.rate >= $signed({3'b000, r_rate_min}))
                     && (i_in.rate <= $signed({3'b000, r_rate_max}));
    assign w_diff     = (w_y >= w_med) ? (w_y - w_med) : (w_med - w_y);
    assign w_dev100   = 15'(w_diff) * 15'(hrmof_pkg::PERCENT_SCALE);
    assign w_lim      = 15'(w_med) * 15'(r_dev);
    assign w_outlier  = (r_count >= CNT_W'(MIN_FILL_FOR_CHECK)) && (w_dev100 > w_lim);
    assign w_run_inc  = r_run + 4'd1;

    always_comb begin
        if (!i_in.rate_valid) begin
            w_status = hrmof_pkg::ST_INVALID;
        end else if (!w_in_range) begin
            w_status = hrmof_pkg::ST_RANGE;
        end else if (w_outlier && (w_run_inc < r_limit)) begin
            w_status = hrmof_pkg::ST_OUTLIER;
        end else if (w_outlier) begin
            w_status = hrmof_pkg::ST_RESET;
        end else begin
            w_status = hrmof_pkg::ST_ACCEPTED;
        end
    end

    assign w_take = w_acc && (w_status == hrmof_pkg::ST_ACCEPTED
                           || w_status == hrmof_pkg::ST_RESET);
    assign w_full = r_count == CNT_W'(HISTORY_DEPTH);

    assign w_ctl.upd = w_take;
    assign w_ctl.clr = w_status == hrmof_pkg::ST_RESET;
    assign w_ctl.rem = w_full && !w_ctl.clr;
    assign w_ctl.x   = r_hist[0];
    assign w_ctl.y   = w_y;

    always_comb begin
        n_count = r_count;
        n_run   = r_run;
        if (w_take) begin
            n_run = 4'd0;
            if (w_ctl.clr) begin
                n_count = CNT_W'(1);
            end else if (!w_full) begin
                n_count = CNT_W'(r_count + 1'b1);
            end
        end else if (w_acc && w_status == hrmof_pkg::ST_OUTLIER) begin
            n_run = w_run_inc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_run   <= 4'd0;
        end else begin
            r_count <= n_count;
            r_run   <= n_run;
        end
    end

    // arrival-order history, oldest at cell 0
    assign w_wpos = w_ctl.clr ? '0 : IDX_W'(r_count);

    always_comb begin
        for (int i = 0; i < HISTORY_DEPTH; i++) begin
            n_hist[i] = r_hist[i];
            if (w_take) begin
                if (w_ctl.rem) begin
                    n_hist[i] = (i == HISTORY_DEPTH - 1) ? w_y : r_hist[(i + 1) % HISTORY_DEPTH];
                end else if (w_wpos == IDX_W'(i)) begin
                    n_hist[i] = w_y;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < HISTORY_DEPTH; i++) begin
            r_hist[i] <= n_hist[i];
        end
    end

    // sorted row
    for (genvar g = 0; g < HISTORY_DEPTH; g++) begin : g_cell
        hrmof_pkg::t_key w_next_key;
        hrmof_pkg::t_key w_prev_rem;
        logic            w_prev_le;

        if (g == HISTORY_DEPTH - 1) begin : g_last
            assign w_next_key = hrmof_pkg::KEY_EMPTY;
        end else begin : g_mid
            assign w_next_key = w_key[g + 1];
        end

        if (g == 0) begin : g_head
            assign w_prev_rem = hrmof_pkg::KEY_EMPTY;
            assign w_prev_le  = 1'b0;
        end else begin : g_body
            assign w_prev_rem = w_rem_key[g - 1];
            assign w_prev_le  = w_le[g - 1];
        end

        hrmof_sort_cell u_cell (
            .i_clk          (i_clk),
            .i_ctl          (w_ctl),
            .i_first        (g == 0),
            .i_valid        (r_count > CNT_W'(g)),
            .i_next_key     (w_next_key),
            .i_prev_rem_key (w_prev_rem),
            .i_prev_le      (w_prev_le),
            .o_key          (w_key[g]),
            .o_rem_key      (w_rem_key[g]),
            .o_le           (w_le[g]),
            .o_value        (w_val[g]),
            .o_next_value   (w_nxt[g])
        );
    end

    // result beat
    assign w_new_idx           = IDX_W'(n_count >> 1);
    assign w_res.filtered_rate = (n_count == '0) ? 9'h1FF : $signed({1'b0, w_nxt[w_new_idx]});
    assign w_res.status        = w_status;

    hrmof_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_acc),
        .o_ready (w_buf_ready),
        .i_data  (w_res),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (o_out)
    );

endmodule

// ===== design/hrmof_sort_cell.sv =====
// One cell of the sorted history row: drop-oldest and insert-new applied together in one register update.
module hrmof_sort_cell (
    input  logic                  i_clk,
    input  hrmof_pkg::t_sort_ctl  i_ctl,
    input  logic                  i_first,
    input  logic                  i_valid,
    input  hrmof_pkg::t_key       i_next_key,
    input  hrmof_pkg::t_key       i_prev_rem_key,
    input  logic                  i_prev_le,
    output hrmof_pkg::t_key       o_key,
    output hrmof_pkg::t_key       o_rem_key,
    output logic                  o_le,
    output logic [7:0]            o_value,
    output logic [7:0]            o_next_value
);

    logic [7:0]      r_val;
    logic [7:0]      n_val;
    hrmof_pkg::t_key w_key;
    logic            w_below;

    assign w_key     = i_valid ? {1'b0, r_val} : hrmof_pkg::KEY_EMPTY;
    assign w_below   = w_key < {1'b0, i_ctl.x};
    assign o_rem_key = (!i_ctl.rem || w_below) ? w_key : i_next_key;
    assign o_le      = o_rem_key <= {1'b0, i_ctl.y};

    always_comb begin
        n_val = r_val;
        if (i_ctl.upd) begin
            if (i_ctl.clr || (!o_le && (i_first || i_prev_le))) begin
                n_val = i_ctl.y;
            end else if (o_le) begin
                n_val = o_rem_key[7:0];
            end else begin
                n_val = i_prev_rem_key[7:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

    assign o_key        = w_key;
    assign o_value      = r_val;
    assign o_next_value = n_val;

endmodule

// ===== design/hrmof_out_buf.sv =====
// Two-entry output skid buffer for result beats.
module hrmof_out_buf (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  hrmof_pkg::t_out   i_data,
    output logic              o_valid,
    input  logic              i_ready,
    output hrmof_pkg::t_out   o_data
);

    logic [1:0]      r_cnt;
    logic [1:0]      n_cnt;
    hrmof_pkg::t_out r_d0;
    hrmof_pkg::t_out r_d1;
    logic            w_push;
    logic            w_pop;

    assign o_ready = r_cnt != 2'd2;
    assign o_valid = r_cnt != 2'd0;
    assign o_data  = r_d0;
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    always_comb begin
        n_cnt = r_cnt + {1'b0, w_push} - {1'b0, w_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push && (r_cnt == 2'd0 || (r_cnt == 2'd1 && w_pop))) begin
            r_d0 <= i_data;
        end else if (w_pop && r_cnt == 2'd2) begin
            r_d0 <= r_d1;
        end
        if (w_push && r_cnt == 2'd1 && !w_pop) begin
            r_d1 <= i_data;
        end
    end

endmodule

// ===== sim/tb.sv =====
// Testbench for the heart-rate median filter: directed and random readings against a predictor.
`timescale 1ns / 1ps

module tb;

    class hr_filter_board;
        localparam int DEPTH     = 5;
        localparam int MIN_FILL  = 3;
        localparam int DUE_SLOTS = 16;

        int              rate_lo;
        int              rate_hi;
        int              dev_pct;
        int              lim;
        logic [7:0]      hist [DEPTH];
        int              fill;
        logic [3:0]      run;
        hrmof_pkg::t_out due_results [DUE_SLOTS];
        int              due_wr;
        int              due_rd;
        int              errors;

        function new();
            rate_lo = int'(hrmof_pkg::RATE_MIN_RST);
            rate_hi = int'(hrmof_pkg::RATE_MAX_RST);
            dev_pct = int'(hrmof_pkg::DEVIATION_RST);
            lim     = int'(hrmof_pkg::REJECT_LIMIT_RST);
            fill    = 0;
            run     = '0;
            due_wr  = 0;
            due_rd  = 0;
            errors  = 0;
        endfunction

        function void set_reg(hrmof_pkg::t_cfg_idx idx, logic [7:0] data);
            case (idx)
                hrmof_pkg::CFG_RATE_MIN:     rate_lo = int'(data);
                hrmof_pkg::CFG_RATE_MAX:     rate_hi = int'(data);
                hrmof_pkg::CFG_DEVIATION:    dev_pct = int'(data[6:0]);
                hrmof_pkg::CFG_REJECT_LIMIT: lim     = int'(data[3:0]);
                default: ;
            endcase
        endfunction

        function int median();
            int tmp [DEPTH];
            int v;
            int j;
            if (fill == 0) return -1;
            for (int i = 0; i < fill; i++) tmp[i] = int'(hist[i]);
            for (int i = 1; i < fill; i++) begin
                v = tmp[i];
                j = i;
                while (j > 0 && tmp[j-1] > v) begin
                    tmp[j] = tmp[j-1];
                    j--;
                end
                tmp[j] = v;
            end
            return tmp[fill / 2];
        endfunction

        function int pending();
            return due_wr - due_rd;
        endfunction

        function void take_reading(hrmof_pkg::t_in item);
            int                 r;
            int                 med;
            int                 d;
            logic [3:0]         nrun;
            hrmof_pkg::t_status st;
            hrmof_pkg::t_out    want;
            r   = int'($signed(item.rate));
            med = median();
            st  = hrmof_pkg::ST_ACCEPTED;
            if (!item.rate_valid) begin
                st = hrmof_pkg::ST_INVALID;
            end else if (r < rate_lo || r > rate_hi) begin
                st = hrmof_pkg::ST_RANGE;
            end else begin
                if (fill >= MIN_FILL && med >= 0) begin
                    d = (r > med) ? r - med : med - r;
                    if (d * int'(hrmof_pkg::PERCENT_SCALE) > med * dev_pct) begin
                        nrun = run + 4'd1;
                        if (int'(nrun) < lim) begin
                            run = nrun;
                            st  = hrmof_pkg::ST_OUTLIER;
                        end else begin
                            fill = 0;
                            st   = hrmof_pkg::ST_RESET;
                        end
                    end
                end
                if (st != hrmof_pkg::ST_OUTLIER) begin
                    run = '0;
                    if (fill >= DEPTH) begin
                        for (int i = 0; i < DEPTH - 1; i++) hist[i] = hist[i+1];
                        fill = DEPTH - 1;
                    end
                    hist[fill] = r[7:0];
                    fill++;
                    med = median();
                end
            end
            want.filtered_rate = 9'(med);
            want.status        = st;
            due_results[due_wr % DUE_SLOTS] = want;
            due_wr++;
        endfunction

        task report_mismatch(string msg);
            errors++;
            $display("mismatch at %0t: %s", $realtime, msg);
        endtask

        task match_beat(hrmof_pkg::t_out got);
            hrmof_pkg::t_out want;
            if (due_wr == due_rd) begin
                report_mismatch($sformatf("unexpected beat: rate %0d status %0d",
                    $signed(got.filtered_rate), got.status));
                return;
            end
            want = due_results[due_rd % DUE_SLOTS];
            due_rd++;
            if (got.filtered_rate !== want.filtered_rate)
                report_mismatch($sformatf("filtered_rate %0d, expected %0d",
                    $signed(got.filtered_rate), $signed(want.filtered_rate)));
            if (got.status !== want.status)
                report_mismatch($sformatf("status %0d, expected %0d", got.status, want.status));
        endtask
    endclass

    logic            i_clk = 1'b0;
    logic            i_rst_n;
    logic            i_in_valid;
    logic            o_in_ready;
    hrmof_pkg::t_in  i_in;
    logic            o_out_valid;
    logic            i_out_ready;
    hrmof_pkg::t_out o_out;
    logic            i_cfg_we;
    logic [1:0]      i_cfg_idx;
    logic [7:0]      i_cfg_data;

    hr_filter_board sb = new();

    int idle_in;
    int stall_out;
    int center;
    int burst_left;
    int burst_val;

    heart_rate_median_outlier_filter dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) sb.match_beat(o_out);
        i_out_ready <= ($urandom_range(99) >= stall_out);
    end

    initial begin
        #200000;
        $display("[heart_rate_median_outlier_filter] ERROR");
        $finish;
    end

    task automatic push_beat(hrmof_pkg::t_in item);
        while ($urandom_range(99) < idle_in) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in       <= item;
        i_in_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        sb.take_reading(item);
    endtask

    task automatic feed(int r, bit v);
        hrmof_pkg::t_in item;
        item.rate       = 11'(r);
        item.rate_valid = v;
        push_beat(item);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic put_reg(hrmof_pkg::t_cfg_idx idx, logic [7:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        sb.set_reg(idx, data);
    endtask

    task automatic load_regs(int lo, int hi, int dev, int rl);
        put_reg(hrmof_pkg::CFG_RATE_MIN, 8'(lo));
        put_reg(hrmof_pkg::CFG_RATE_MAX, 8'(hi));
        put_reg(hrmof_pkg::CFG_DEVIATION, 8'(dev));
        put_reg(hrmof_pkg::CFG_REJECT_LIMIT, 8'(rl));
        i_cfg_we <= 1'b0;
    endtask

    function automatic hrmof_pkg::t_in next_reading();
        hrmof_pkg::t_in item;
        int  lo;
        int  hi;
        int  sel;
        int  span;
        int  r;
        lo  = sb.rate_lo;
        hi  = (sb.rate_hi < lo) ? lo : sb.rate_hi;
        sel = $urandom_range(99);
        item.rate_valid = 1'b1;
        if (burst_left > 0) begin
            r = burst_val;
            burst_left--;
        end else if (sel < 6) begin
            r = $urandom_range(2047) - 1024;
            item.rate_valid = 1'b0;
        end else if (sel < 12) begin
            r = $urandom_range(2047) - 1024;
        end else if (sel < 18) begin
            case ($urandom_range(3))
                0: r = lo - 1;
                1: r = hi + 1;
                2: r = lo;
                default: r = hi;
            endcase
        end else if (sel < 22) begin
            burst_left = $urandom_range(16, 1) - 1;
            burst_val  = lo + $urandom_range(hi - lo);
            r = burst_val;
        end else if (sel < 30) begin
            r = lo + $urandom_range(hi - lo);
        end else begin
            if ($urandom_range(19) == 0 || center < lo || center > hi)
                center = lo + $urandom_range(hi - lo);
            span = 1 + center / 16;
            r = center - span + $urandom_range(2 * span);
            if (r < lo) r = lo;
            if (r > hi) r = hi;
        end
        item.rate = 11'(r);
        return item;
    endfunction

    initial begin
        int plan_lo  [6] = '{40, 0, 60, 255, 30, 100};
        int plan_hi  [6] = '{180, 255, 120, 255, 220, 140};
        int plan_dev [6] = '{20, 0, 100, 127, 10, 5};
        int plan_lim [6] = '{3, 1, 15, 0, 2, 4};
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_in        <= '0;
        i_out_ready <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_idx   <= hrmof_pkg::CFG_RATE_MIN;
        i_cfg_data  <= '0;
        idle_in     = 38;
        stall_out   = 67;
        center      = 80;
        burst_left  = 0;
        burst_val   = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // register defaults after reset
        feed(1023, 1'b0);
        feed(-1024, 1'b1);
        feed(1023, 1'b1);
        feed(-1, 1'b1);
        feed(39, 1'b1);
        feed(181, 1'b1);
        feed(40, 1'b1);
        feed(180, 1'b1);
        feed(100, 1'b1);
        feed(100, 1'b1);
        feed(150, 1'b1);
        feed(60, 1'b1);
        feed(121, 1'b1);
        feed(120, 1'b1);
        feed(122, 1'b1);
        feed(119, 1'b1);
        feed(144, 1'b1);
        feed(145, 1'b1);
        feed(97, 1'b1);
        drain();
        // empty range
        load_regs(200, 50, 20, 3);
        feed(100, 1'b1);
        feed(200, 1'b1);
        feed(50, 1'b1);
        drain();
        // zero reject limit, zero deviation
        load_regs(0, 255, 0, 0);
        feed(255, 1'b1);
        feed(0, 1'b1);
        feed(0, 1'b1);

        for (int ph = 0; ph < 6; ph++) begin
            drain();
            idle_in   = (ph < 2) ? 38 : (ph < 4) ? 67 : 0;
            stall_out = (ph < 2) ? 67 : (ph < 4) ? 38 : 0;
            load_regs(plan_lo[ph], plan_hi[ph], plan_dev[ph], plan_lim[ph]);
            burst_left = 0;
            for (int n = 0; n < 80; n++) push_beat(next_reading());
        end
        drain();
        repeat (8) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("[heart_rate_median_outlier_filter] OK");
        else
            $display("[heart_rate_median_outlier_filter] ERROR");
        $finish;
    end
endmodule
